// ===== design/reds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reds_pkg: shared types and constants of the encoder step detector
// Field widths, the per-lane result record and the register reset value.
// ----------------------------------------------------------------------------
package reds_pkg;

    localparam int PIN_W      = 8;   // pins per level field, one per channel
    localparam int CNT_W      = 8;   // idle counter / threshold width
    localparam int IN_DATA_W  = 16;  // levels_a, levels_b
    localparam int OUT_DATA_W = 16;  // step_mask, clockwise_mask

    localparam logic [CNT_W-1:0] IDLE_TICKS_RST = 8'd20;
    localparam logic [CNT_W-1:0] CNT_MAX        = 8'hFF;

    typedef struct packed {
        logic step;   // lane confirmed one step on this beat
        logic fwd;    // direction of that step, 1 forward
    } t_lane_res;

    typedef struct packed {
        logic [PIN_W-1:0] fwd_mask;
        logic [PIN_W-1:0] step_mask;
    } t_masks;

endpackage

// ===== design/rotary_encoder_step_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_step_detector_unit: quadrature encoder step detector
// One lane per encoder channel; lane flags are merged into two 8-bit masks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave beat = one sampling tick: A and B pin levels of every channel.
//   Master beat = one result per tick: step flags and direction flags.
//   Each channel waits for both pins high over idle_ticks beats, then
//   detects the first falling pin, confirms it and classifies the other pin,
//   confirms the class one beat later and flags one step with direction.
//   Output: a result beat is valid the cycle after the slave beat is taken unless the output is stalled.
//   Throughput: one beat per cycle while s_axis_tready is high; all lanes update in the accepting cycle.
//   Stall: a 2-entry output buffer (register + skid) keeps s_axis_tready high
//   after m_axis_tready drops, until the skid entry is filled; it falls only
//   while both entries hold results.
//   Reset (sync, active low): every lane idle with a cleared counter, buffer
//   empty, idle_ticks = 20.
//   Config: i_cfg_wr_en writes idle_ticks; write only while the unit is idle.
//   Lanes 8 and up (CHANNELS > 8) see both pins low and never show in the
//   result masks.
// ----------------------------------------------------------------------------
module rotary_encoder_step_detector_unit #(
    parameter int CHANNELS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: idle_ticks
    input  logic                               i_cfg_wr_en,
    input  logic [reds_pkg::CNT_W-1:0]         i_cfg_wr_data,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [reds_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] levels_a, [15:8] levels_b
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [reds_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // [7:0] step_mask, [15:8] clockwise_mask
);
    import reds_pkg::*;

    logic [CNT_W-1:0] r_idle_ticks;
    logic             w_accept;
    t_lane_res        w_res [CHANNELS];
    t_masks           w_masks;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= IDLE_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            r_idle_ticks <= i_cfg_wr_data;
        end
    end

    // one detector per channel; only the first eight see the pins
    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        logic w_a, w_b;
        if (i < PIN_W) begin : g_pins
            assign w_a = s_axis_tdata[i];
            assign w_b = s_axis_tdata[PIN_W + i];
        end else begin : g_nopins
            assign w_a = 1'b0;
            assign w_b = 1'b0;
        end

        reds_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_accept),
            .i_pin_a      (w_a),
            .i_pin_b      (w_b),
            .i_idle_ticks (r_idle_ticks),
            .o_res        (w_res[i])
        );
    end

    // gather lane flags into the result masks
    for (genvar k = 0; k < PIN_W; k++) begin : g_mask
        if (k < CHANNELS) begin : g_used
            assign w_masks.step_mask[k] = w_res[k].step;
            assign w_masks.fwd_mask[k]  = w_res[k].fwd;
        end else begin : g_unused
            assign w_masks.step_mask[k] = 1'b0;
            assign w_masks.fwd_mask[k]  = 1'b0;
        end
    end

    reds_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_accept),
        .i_masks       (w_masks),
        .o_ready       (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== design/reds_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reds_lane: one encoder channel
// Eight-phase detector with saturating idle counter; result is combinational
// from the current phase and the pins of the beat being accepted.
// ----------------------------------------------------------------------------
module reds_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_pin_a,
    input  logic                          i_pin_b,
    input  logic [reds_pkg::CNT_W-1:0]    i_idle_ticks,
    output reds_pkg::t_lane_res           o_res
);
    import reds_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_LOW_CHECK = 3'd1;
    localparam logic [2:0] PH_A_CONFIRM = 3'd2;
    localparam logic [2:0] PH_A_B_HIGH  = 3'd3;
    localparam logic [2:0] PH_A_B_LOW   = 3'd4;
    localparam logic [2:0] PH_B_CONFIRM = 3'd5;
    localparam logic [2:0] PH_B_A_HIGH  = 3'd6;
    localparam logic [2:0] PH_B_A_LOW   = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] w_cnt_inc;

    assign w_cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_res   = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_pin_a && i_pin_b) begin
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc >= i_idle_ticks) begin
                        n_phase = PH_LOW_CHECK;
                    end
                end else begin
                    n_cnt = '0;
                end
            end
            PH_LOW_CHECK: begin
                if (!i_pin_a) begin
                    n_phase = PH_A_CONFIRM;
                end else if (!i_pin_b) begin
                    n_phase = PH_B_CONFIRM;
                end
            end
            PH_A_CONFIRM: begin
                if (!i_pin_a) begin
                    n_phase = i_pin_b ? PH_A_B_HIGH : PH_A_B_LOW;
                end else begin
                    n_phase = PH_LOW_CHECK;
                end
            end
            PH_B_CONFIRM: begin
                if (!i_pin_b) begin
                    n_phase = i_pin_a ? PH_B_A_HIGH : PH_B_A_LOW;
                end else begin
                    n_phase = PH_LOW_CHECK;
                end
            end
            PH_A_B_HIGH: begin
                o_res.step = i_pin_b;
                o_res.fwd  = i_pin_b;
                n_phase    = PH_IDLE;
                n_cnt      = '0;
            end
            PH_A_B_LOW: begin
                o_res.step = !i_pin_b;
                n_phase    = PH_IDLE;
                n_cnt      = '0;
            end
            PH_B_A_HIGH: begin
                o_res.step = i_pin_a;
                n_phase    = PH_IDLE;
                n_cnt      = '0;
            end
            PH_B_A_LOW: begin
                o_res.step = !i_pin_a;
                o_res.fwd  = !i_pin_a;
                n_phase    = PH_IDLE;
                n_cnt      = '0;
            end
            default: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // a step only leaves one of the four classified phases
    a_step_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.step |-> (r_phase == PH_A_B_HIGH || r_phase == PH_A_B_LOW ||
                        r_phase == PH_B_A_HIGH || r_phase == PH_B_A_LOW))
        else $error("step outside a classified phase");

    // any accepted beat from a classified phase returns to idle with a clear count
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase >= PH_A_B_HIGH && r_phase != PH_B_CONFIRM)
            |=> (r_phase == PH_IDLE && r_cnt == '0))
        else $error("lane did not return to idle after classification");

endmodule

// ===== design/reds_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reds_merge: result merge and output buffer
// Registers the merged lane masks; a skid entry keeps the input side open
// for one more beat while the output is stalled.
// ----------------------------------------------------------------------------
module reds_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  reds_pkg::t_masks                   i_masks,
    output logic                               o_ready,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [reds_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import reds_pkg::*;

    t_masks r_out, r_skid;
    logic   r_out_valid, r_skid_valid;
    logic   w_pop;

    assign w_pop         = r_out_valid && m_axis_tready;
    assign o_ready       = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_out_valid || w_pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= i_masks;
            end else begin
                r_skid <= i_masks;
            end
        end else if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output beat");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push while buffer full");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("stalled beat not captured in skid");

    a_dir_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.fwd_mask & ~r_out.step_mask) == '0))
        else $error("direction bit without step");

endmodule

// ===== tb/rotary_encoder_step_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_step_detector_unit_tb: self-checking bench for the step detector
// Drives pin-level ticks over the slave stream, predicts each lane's phase
// machine in the bench and checks every result beat in order. Covers the
// reset threshold, directed confirm and fail paths, counter saturation,
// output back-pressure and random quadrature traffic under several thresholds.
// ----------------------------------------------------------------------------
module rotary_encoder_step_detector_unit_tb;

    import reds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_ARMED     = 3'd1,
        ST_A_CONFIRM = 3'd2,
        ST_A_FWD     = 3'd3,
        ST_A_REV     = 3'd4,
        ST_B_CONFIRM = 3'd5,
        ST_B_REV     = 3'd6,
        ST_B_FWD     = 3'd7
    } t_lane_state;

    // quadrature patterns played by the random lane generators
    typedef enum int {
        PAT_A_FWD = 0,
        PAT_A_REV = 1,
        PAT_B_REV = 2,
        PAT_B_FWD = 3
    } t_pattern;

    localparam int LANES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CNT_W-1:0]      i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] levels_a, [15:8] levels_b
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] step_mask, [15:8] clockwise_mask

    // bench model of the lanes
    t_lane_state      lane_state [LANES];
    logic [CNT_W-1:0] lane_count [LANES];
    logic [CNT_W-1:0] idle_ticks_q;

    t_masks step_exp_q [$];

    // random lane generators
    int lane_hi  [LANES];
    int lane_pat [LANES];
    int lane_pos [LANES];

    bit rst_done;
    bit tx_gaps;
    bit rx_gaps;
    int rx_hold;
    int mismatches;
    int n_ticks;
    int n_steps;
    int n_cfg;

    rotary_encoder_step_detector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic void reset_lanes();
        idle_ticks_q = IDLE_TICKS_RST;
        for (int i = 0; i < LANES; i++) begin
            lane_state[i] = ST_IDLE;
            lane_count[i] = '0;
        end
    endfunction

    // advance every lane by one tick, return the step and direction masks
    function automatic t_masks predict_tick(logic [PIN_W-1:0] a, logic [PIN_W-1:0] b);
        t_masks res;
        logic   pa;
        logic   pb;
        res = '0;
        for (int i = 0; i < LANES; i++) begin
            pa = a[i];
            pb = b[i];
            case (lane_state[i])
                ST_IDLE: begin
                    if (pa && pb) begin
                        if (lane_count[i] != CNT_MAX)
                            lane_count[i] = lane_count[i] + 1'b1;
                        if (lane_count[i] >= idle_ticks_q)
                            lane_state[i] = ST_ARMED;
                    end else begin
                        lane_count[i] = '0;
                    end
                end
                ST_ARMED: begin
                    if (!pa)
                        lane_state[i] = ST_A_CONFIRM;
                    else if (!pb)
                        lane_state[i] = ST_B_CONFIRM;
                end
                ST_A_CONFIRM: begin
                    if (!pa)
                        lane_state[i] = pb ? ST_A_FWD : ST_A_REV;
                    else
                        lane_state[i] = ST_ARMED;
                end
                ST_B_CONFIRM: begin
                    if (!pb)
                        lane_state[i] = pa ? ST_B_REV : ST_B_FWD;
                    else
                        lane_state[i] = ST_ARMED;
                end
                default: begin
                    // final confirm phases, every one returns to idle
                    case (lane_state[i])
                        ST_A_FWD: if (pb) begin
                            res.step_mask[i] = 1'b1;
                            res.fwd_mask[i]  = 1'b1;
                        end
                        ST_A_REV: if (!pb) res.step_mask[i] = 1'b1;
                        ST_B_REV: if (pa)  res.step_mask[i] = 1'b1;
                        default:  if (!pa) begin
                            res.step_mask[i] = 1'b1;
                            res.fwd_mask[i]  = 1'b1;
                        end
                    endcase
                    lane_state[i] = ST_IDLE;
                    lane_count[i] = '0;
                end
            endcase
        end
        return res;
    endfunction

    // one well-formed lane sequence: high run, then a three-tick pattern
    function automatic logic [1:0] next_lane_pins(int ch);
        logic r;
        logic [1:0] ab;
        r = 1'($urandom_range(0, 1));
        if (lane_hi[ch] > 0) begin
            lane_hi[ch]--;
            return 2'b11;
        end
        case (lane_pat[ch])
            PAT_A_FWD: ab = (lane_pos[ch] == 0) ? {1'b0, r} :
                            (lane_pos[ch] == 1) ? 2'b01 : {r, 1'b1};
            PAT_A_REV: ab = (lane_pos[ch] == 0) ? {1'b0, r} :
                            (lane_pos[ch] == 1) ? 2'b00 : {r, 1'b0};
            PAT_B_REV: ab = (lane_pos[ch] == 0) ? 2'b10 :
                            (lane_pos[ch] == 1) ? 2'b10 : {1'b1, r};
            default:   ab = (lane_pos[ch] == 0) ? 2'b10 :
                            (lane_pos[ch] == 1) ? 2'b00 : {1'b0, r};
        endcase
        lane_pos[ch]++;
        if (lane_pos[ch] == 3) begin
            lane_pos[ch] = 0;
            lane_pat[ch] = $urandom_range(PAT_A_FWD, PAT_B_FWD);
            lane_hi[ch]  = int'(idle_ticks_q) + $urandom_range(0, 2);
        end
        return ab;
    endfunction

    task automatic send_tick(logic [PIN_W-1:0] a, logic [PIN_W-1:0] b);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        step_exp_q.push_back(predict_tick(a, b));
        n_ticks++;
    endtask

    // sender goes quiet until every expected result has arrived
    task automatic wait_all_results();
        int waited;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        for (waited = 0; waited < 5000 && step_exp_q.size() != 0; waited++)
            @(posedge i_clk);
        if (step_exp_q.size() != 0) begin
            mismatches += step_exp_q.size();
            $display("%0t: %0d result beats never arrived", $realtime, step_exp_q.size());
            step_exp_q.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idle_ticks(logic [CNT_W-1:0] val);
        wait_all_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        idle_ticks_q  = val;
        n_cfg++;
    endtask

    task automatic send_random_tick();
        logic [PIN_W-1:0] a;
        logic [PIN_W-1:0] b;
        logic [1:0]       ab;
        if ($urandom_range(0, 19) == 0) begin
            a = PIN_W'($urandom);
            b = PIN_W'($urandom);
        end else begin
            for (int i = 0; i < LANES; i++) begin
                ab = next_lane_pins(i);
                if ($urandom_range(0, 29) == 0)
                    ab = 2'($urandom);
                a[i] = ab[1];
                b[i] = ab[0];
            end
        end
        send_tick(a, b);
    endtask

    // threshold straight out of reset, no register write yet
    task automatic test_reset_threshold();
        repeat (21) send_tick(8'hFF, 8'hFF);
        send_tick(8'h00, 8'hFF);
        send_tick(8'h00, 8'hFF);
        send_tick(8'hFF, 8'hFF);
    endtask

    task automatic test_directed_paths();
        set_idle_ticks(8'd1);
        send_tick(8'h00, 8'h00);
        send_tick(8'hFF, 8'hFF);
        send_tick(8'hF0, 8'h0F);   // low half A first, high half B first
        send_tick(8'h30, 8'h03);
        send_tick(8'h30, 8'h03);   // all four step kinds
        send_tick(8'hFF, 8'hFF);
        send_tick(8'h00, 8'hFF);
        send_tick(8'hFF, 8'hFF);   // A confirm fails
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFF, 8'hFF);   // B confirm fails
        send_tick(8'h00, 8'h00);   // A wins when both fall
        send_tick(8'h00, 8'h00);
        send_tick(8'hFF, 8'hFF);   // reverse class not confirmed
        send_tick(8'hFF, 8'hFF);
        send_tick(8'hAA, 8'h55);
        send_tick(8'hAA, 8'h00);
        send_tick(8'hFF, 8'hFF);
        send_tick(8'hFF, 8'hFF);
        send_tick(8'h7F, 8'hFF);
        send_tick(8'h7F, 8'hFF);
        send_tick(8'hFF, 8'h7F);
        set_idle_ticks(8'd0);      // zero threshold arms on one high tick
        send_tick(8'hFF, 8'hFF);
        send_tick(8'hFF, 8'h00);
        send_tick(8'h00, 8'h00);
        send_tick(8'h00, 8'hFF);
    endtask

    task automatic test_counter_saturation();
        set_idle_ticks(CNT_MAX);
        repeat (257) send_tick(8'hFF, 8'hFF);
        send_tick(8'hFF, 8'h00);
        send_tick(8'h00, 8'h00);
        send_tick(8'h00, 8'hFF);
    endtask

    task automatic test_backpressure();
        set_idle_ticks(8'd2);
        tx_gaps = 1'b0;
        rx_hold = 150;
        repeat (40) send_random_tick();
        tx_gaps = 1'b1;
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        logic [CNT_W-1:0] thr [6];
        thr = '{8'd1, 8'd0, 8'd3, 8'd2, 8'd5, 8'd1};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                thr[ph] = CNT_W'($urandom_range(1, 8));
            set_idle_ticks(thr[ph]);
            tx_gaps = (ph != 3);
            rx_gaps = (ph != 3);
            repeat (84) send_random_tick();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // result side: random stalls, plus a long hold when a test asks for one
    initial begin
        int stall;
        wait (rst_done);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_gaps ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_masks got;
        t_masks want;
        if (rst_done && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got = m_axis_tdata;
            if (step_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat %04h", $realtime, m_axis_tdata);
            end else begin
                want = step_exp_q.pop_front();
                n_steps += $countones(got.step_mask);
                if (got.step_mask !== want.step_mask || got.fwd_mask !== want.fwd_mask) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: step_mask exp %02h got %02h, clockwise_mask exp %02h got %02h",
                                 $realtime, want.step_mask, got.step_mask,
                                 want.fwd_mask, got.fwd_mask);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("rotary_encoder_step_detector_unit_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        rx_hold       = 0;
        rst_done      = 1'b0;
        mismatches    = 0;
        n_ticks       = 0;
        n_steps       = 0;
        n_cfg         = 0;
        for (int i = 0; i < LANES; i++) begin
            lane_hi[i]  = 0;
            lane_pat[i] = $urandom_range(PAT_A_FWD, PAT_B_FWD);
            lane_pos[i] = 0;
        end
        reset_lanes();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        test_reset_threshold();
        test_directed_paths();
        test_counter_saturation();
        test_backpressure();
        test_random_traffic();
        wait_all_results();

        $display("covered %0d ticks, %0d confirmed steps, %0d threshold writes",
                 n_ticks, n_steps, n_cfg);
        $display("incl. reset threshold, zero and full thresholds, long output stall");
        if (mismatches == 0) begin
            $display("rotary_encoder_step_detector_unit_tb: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("rotary_encoder_step_detector_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
